FILE: design/cdl_pkg.sv
// package: request codes and the command and status bundles between controller and datapath
package cdl_pkg;

    localparam logic [1:0] REQ_HDR  = 2'd0;
    localparam logic [1:0] REQ_EXP  = 2'd1;
    localparam logic [1:0] REQ_CHAR = 2'd2;

    typedef struct packed {
        logic write_entry;
        logic write_exp;
        logic start_char;
        logic probe;
        logic step;
        logic hit;
        logic load_miss;
        logic load_empty;
        logic exp_load;
    } cmd_t;

    typedef struct packed {
        logic search_done;
        logic key_lt;
        logic key_gt;
        logic len_zero;
        logic exp_last;
        logic out_free;
    } sts_t;

endpackage

FILE: design/cdl_ctrl.sv
// controller: state machine sequencing table writes, binary search and result emission
module cdl_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        req_type,
    input  cdl_pkg::sts_t     sts,
    output logic              in_ready,
    output cdl_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROBE = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_MISS  = 3'd3;
    localparam logic [2:0] S_EMPTY = 3'd4;
    localparam logic [2:0] S_EXP   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (req_type)
                        cdl_pkg::REQ_HDR:  cmd.write_entry = 1'b1;
                        cdl_pkg::REQ_EXP:  cmd.write_exp = 1'b1;
                        cdl_pkg::REQ_CHAR:
                        begin
                            cmd.start_char = 1'b1;
                            state_next     = S_PROBE;
                        end
                        default: ;
                    endcase
                end
            end
            S_PROBE:
            begin
                if (sts.search_done)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    cmd.probe  = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.key_lt || sts.key_gt)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_PROBE;
                end
                else
                begin
                    cmd.hit    = 1'b1;
                    state_next = sts.len_zero ? S_EMPTY : S_EXP;
                end
            end
            S_MISS:
            begin
                if (sts.out_free)
                begin
                    cmd.load_miss = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.load_empty = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_EXP:
            begin
                if (sts.out_free)
                begin
                    cmd.exp_load = 1'b1;
                    if (sts.exp_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/cdl_dpath.sv
// datapath: entry and expansion memories, search bounds, position counters, output register
module cdl_dpath #(
    parameter int TABLE_DEPTH   = 1024,
    parameter int MAX_EXPANSION = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cdl_pkg::cmd_t     cmd,
    output cdl_pkg::sts_t     sts,
    input  logic              entry_count_we,
    input  logic [10:0]       entry_count,
    input  logic [9:0]        entry_index,
    input  logic [15:0]       entry_key,
    input  logic [3:0]        entry_length,
    input  logic [2:0]        expansion_pos,
    input  logic [15:0]       expansion_char,
    input  logic [15:0]       in_char,
    input  logic              string_start,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [15:0]       out_char,
    output logic              char_valid,
    output logic              map_valid,
    output logic [31:0]       map_in_pos,
    output logic [31:0]       map_out_pos,
    output logic              last
);

    localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int LEN_W     = $clog2(MAX_EXPANSION + 1);
    localparam int ENT_W     = 16 + LEN_W;
    localparam int EXP_DEPTH = TABLE_DEPTH * MAX_EXPANSION;
    localparam int EXP_AW    = (EXP_DEPTH > 1) ? $clog2(EXP_DEPTH) : 1;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (&v) ? v : v + 32'd1;
    endfunction

    // memories
    logic [ENT_W-1:0] entry_mem [TABLE_DEPTH];
    logic [15:0]      exp_mem   [EXP_DEPTH];
    logic [ENT_W-1:0] entry_q_reg;
    logic [15:0]      exp_q_reg;

    // configuration and search state
    logic [10:0]      entry_count_reg;
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] hi_reg;
    logic [CNT_W-1:0] mid_reg;
    logic [15:0]      in_char_reg;
    logic [LEN_W-1:0] n_reg;
    logic [LEN_W-1:0] j_reg;
    logic [EXP_AW-1:0] base_reg;
    logic [31:0]      in_count_reg;
    logic [31:0]      out_count_reg;

    // output register
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [15:0]      out_char_reg;
    logic             char_valid_reg;
    logic             map_valid_reg;
    logic [31:0]      map_in_pos_reg;
    logic [31:0]      map_out_pos_reg;
    logic             last_reg;

    logic [31:0]      idx32;
    logic             idx_ok;
    logic [LEN_W-1:0] len_clip;
    logic             ent_we;
    logic             exp_we;
    logic [31:0]      exp_wsum;
    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] hi_init;
    logic [15:0]      key_q;
    logic [LEN_W-1:0] len_q;
    logic [31:0]      base_sum;
    logic [31:0]      next_sum;
    logic             exp_re;
    logic [EXP_AW-1:0] exp_raddr;
    logic [31:0]      out_inc;
    logic             load_any;

    assign idx32    = 32'(entry_index);
    assign idx_ok   = idx32 < 32'(TABLE_DEPTH);
    assign len_clip = (32'(entry_length) > 32'(MAX_EXPANSION)) ? LEN_W'(MAX_EXPANSION)
                                                               : LEN_W'(entry_length);
    assign ent_we   = cmd.write_entry && idx_ok;
    assign exp_we   = cmd.write_exp && idx_ok
                      && (32'(expansion_pos) < 32'(MAX_EXPANSION));
    assign exp_wsum = idx32 * 32'(MAX_EXPANSION) + 32'(expansion_pos);

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[CNT_W:1];
    assign hi_init  = (32'(entry_count_reg) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                                : CNT_W'(entry_count_reg);

    assign key_q    = entry_q_reg[ENT_W-1:LEN_W];
    assign len_q    = entry_q_reg[LEN_W-1:0];

    assign base_sum = 32'(mid_reg) * 32'(MAX_EXPANSION);
    assign next_sum = 32'(base_reg) + 32'(j_reg) + 32'd1;
    assign exp_re   = cmd.hit || (cmd.exp_load && !sts.exp_last);
    assign exp_raddr = cmd.hit ? base_sum[EXP_AW-1:0] : next_sum[EXP_AW-1:0];

    assign out_inc  = sat_inc(out_count_reg);
    assign load_any = cmd.load_miss || cmd.load_empty || cmd.exp_load;

    assign sts.search_done = !(lo_reg < hi_reg);
    assign sts.key_lt      = in_char_reg < key_q;
    assign sts.key_gt      = key_q < in_char_reg;
    assign sts.len_zero    = (len_q == '0);
    assign sts.exp_last    = (({1'b0, j_reg} + 1'b1) == {1'b0, n_reg});
    assign sts.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[idx32[IDX_W-1:0]] <= {entry_key, len_clip};
        end
        if (cmd.probe)
        begin
            entry_q_reg <= entry_mem[mid[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (exp_we)
        begin
            exp_mem[exp_wsum[EXP_AW-1:0]] <= expansion_char;
        end
        if (exp_re)
        begin
            exp_q_reg <= exp_mem[exp_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            mid_reg         <= '0;
            in_count_reg    <= '0;
            out_count_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (entry_count_we)
            begin
                entry_count_reg <= entry_count;
            end
            if (cmd.start_char)
            begin
                lo_reg        <= '0;
                hi_reg        <= hi_init;
                in_count_reg  <= string_start ? 32'd1 : sat_inc(in_count_reg);
                out_count_reg <= string_start ? 32'd0 : out_count_reg;
            end
            if (cmd.probe)
            begin
                mid_reg <= mid;
            end
            if (cmd.step)
            begin
                if (sts.key_lt)
                begin
                    hi_reg <= mid_reg;
                end
                else
                begin
                    lo_reg <= mid_reg + 1'b1;
                end
            end
            if (cmd.load_miss || cmd.exp_load)
            begin
                out_count_reg <= out_inc;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (load_any)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_char)
        begin
            in_char_reg <= in_char;
        end
        if (cmd.hit)
        begin
            n_reg    <= len_q;
            j_reg    <= '0;
            base_reg <= base_sum[EXP_AW-1:0];
        end
        if (cmd.exp_load)
        begin
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.load_miss)
        begin
            out_char_reg    <= in_char_reg;
            char_valid_reg  <= 1'b1;
            map_valid_reg   <= 1'b0;
            map_in_pos_reg  <= '0;
            map_out_pos_reg <= '0;
            last_reg        <= 1'b1;
        end
        else if (cmd.load_empty)
        begin
            out_char_reg    <= '0;
            char_valid_reg  <= 1'b0;
            map_valid_reg   <= 1'b1;
            map_in_pos_reg  <= in_count_reg;
            map_out_pos_reg <= out_count_reg;
            last_reg        <= 1'b1;
        end
        else if (cmd.exp_load)
        begin
            out_char_reg    <= exp_q_reg;
            char_valid_reg  <= 1'b1;
            map_valid_reg   <= sts.exp_last;
            map_in_pos_reg  <= sts.exp_last ? in_count_reg : 32'd0;
            map_out_pos_reg <= sts.exp_last ? out_inc : 32'd0;
            last_reg        <= sts.exp_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign char_valid  = char_valid_reg;
    assign map_valid   = map_valid_reg;
    assign map_in_pos  = map_in_pos_reg;
    assign map_out_pos = map_out_pos_reg;
    assign last        = last_reg;

`ifndef ASSERT_OFF
    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("search bounds crossed");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_any |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while held");

    a_exp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exp_load |-> (j_reg < n_reg))
        else $error("expansion index beyond entry length");

    a_in_count_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_char |=> (in_count_reg != 32'd0))
        else $error("input position not advanced");
`endif

endmodule

FILE: design/char_decomposition_lookup.sv
// top level: character decomposition lookup with table load and binary search
//
// input channel (in_valid/in_ready): one item per request; req_type selects a
// header write, an expansion write or a character to decompose. writes give no
// result, and the block stays ready for the next item. a character is searched
// over the first entry_count entries, at most TABLE_DEPTH (at most 11 probes for
// 1024 entries, each one registered read of the entry memory, then a compare).
// a miss gives one result; a hit of length zero gives one mapping result; other
// hits give their results from the expansion memory, one per cycle while the
// output register is free, up to the entry length. a new item is taken
// once the last result of the current one sits in the output register.
// output channel (out_valid/out_ready): the output register holds a result while
// out_ready is low; the block waits and loses nothing. entry_count_we writes
// entry_count; the user must do so only while the block is idle (not enforced).
// reset clears the position counters, entry_count and the handshake state;
// table memories keep no reset and must be written before they are searched.
module char_decomposition_lookup #(
    parameter int TABLE_DEPTH   = 1024,
    parameter int MAX_EXPANSION = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        entry_count_we,
    input  logic [10:0] entry_count,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [9:0]  entry_index,
    input  logic [15:0] entry_key,
    input  logic [3:0]  entry_length,
    input  logic [2:0]  expansion_pos,
    input  logic [15:0] expansion_char,
    input  logic [15:0] in_char,
    input  logic        string_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_char,
    output logic        char_valid,
    output logic        map_valid,
    output logic [31:0] map_in_pos,
    output logic [31:0] map_out_pos,
    output logic        last
);

    cdl_pkg::cmd_t cmd;
    cdl_pkg::sts_t sts;

    cdl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    cdl_dpath #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .MAX_EXPANSION (MAX_EXPANSION)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .entry_count_we (entry_count_we),
        .entry_count    (entry_count),
        .entry_index    (entry_index),
        .entry_key      (entry_key),
        .entry_length   (entry_length),
        .expansion_pos  (expansion_pos),
        .expansion_char (expansion_char),
        .in_char        (in_char),
        .string_start   (string_start),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .out_char       (out_char),
        .char_valid     (char_valid),
        .map_valid      (map_valid),
        .map_in_pos     (map_in_pos),
        .map_out_pos    (map_out_pos),
        .last           (last)
    );

endmodule

FILE: sim/tb.sv
// testbench: character decomposition lookup against a behavioural model, directed then random
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH          = 1024;
    localparam int MAX_EXP        = 8;
    localparam int FILL           = 16;
    localparam int SETTLE         = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  req;
        logic [9:0]  idx;
        logic [15:0] key;
        logic [3:0]  len;
        logic [2:0]  pos;
        logic [15:0] xch;
        logic [15:0] ch;
        logic        start;
    } req_item_t;

    typedef struct packed {
        logic [15:0] out_char;
        logic        char_valid;
        logic        map_valid;
        logic [31:0] in_pos;
        logic [31:0] out_pos;
        logic        last;
    } result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        req_item_t   item;
        logic [10:0] count_val;
        logic        typed;
        result_t     want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        entry_count_we;
    logic [10:0] entry_count;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [9:0]  entry_index;
    logic [15:0] entry_key;
    logic [3:0]  entry_length;
    logic [2:0]  expansion_pos;
    logic [15:0] expansion_char;
    logic [15:0] in_char;
    logic        string_start;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] out_char;
    logic        char_valid;
    logic        map_valid;
    logic [31:0] map_in_pos;
    logic [31:0] map_out_pos;
    logic        last;

    // model state
    logic [15:0] key_mem [DEPTH];
    logic [3:0]  len_mem [DEPTH];
    logic [15:0] exp_mem [DEPTH * MAX_EXP];
    logic [31:0] cnt_in;
    logic [31:0] cnt_out;
    logic [10:0] cfg_count;

    result_t    out_due_q [$];
    result_t    step_res_q [$];
    dir_row_t   dir_rows [$];
    result_t    blank_res = '0;
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         rcv_stall_pct = 0;
    int         hold_asks = 0;
    int         holds_done = 0;
    int         idle_cycles = 0;

    char_decomposition_lookup #(
        .TABLE_DEPTH   (DEPTH),
        .MAX_EXPANSION (MAX_EXP)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .entry_count_we (entry_count_we),
        .entry_count    (entry_count),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .entry_index    (entry_index),
        .entry_key      (entry_key),
        .entry_length   (entry_length),
        .expansion_pos  (expansion_pos),
        .expansion_char (expansion_char),
        .in_char        (in_char),
        .string_start   (string_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_char       (out_char),
        .char_valid     (char_valid),
        .map_valid      (map_valid),
        .map_in_pos     (map_in_pos),
        .map_out_pos    (map_out_pos),
        .last           (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void add_step(input result_t r);
        step_res_q = {step_res_q, r};
    endfunction

    function automatic void add_row(input dir_row_t r);
        dir_rows = {dir_rows, r};
    endfunction

    function automatic req_item_t any_item(input logic [1:0] req);
        req_item_t it;
        it.req   = req;
        it.idx   = 10'($urandom);
        it.key   = 16'($urandom);
        it.len   = 4'($urandom);
        it.pos   = 3'($urandom);
        it.xch   = 16'($urandom);
        it.ch    = 16'($urandom);
        it.start = 1'($urandom);
        return it;
    endfunction

    function automatic req_item_t hdr_item(input logic [9:0] idx, input logic [15:0] key,
                                           input logic [3:0] len);
        req_item_t it = any_item(cdl_pkg::REQ_HDR);
        it.idx = idx;
        it.key = key;
        it.len = len;
        return it;
    endfunction

    function automatic req_item_t exp_item(input logic [9:0] idx, input logic [2:0] pos,
                                           input logic [15:0] xch);
        req_item_t it = any_item(cdl_pkg::REQ_EXP);
        it.idx = idx;
        it.pos = pos;
        it.xch = xch;
        return it;
    endfunction

    function automatic req_item_t char_item(input logic [15:0] ch, input logic start);
        req_item_t it = any_item(cdl_pkg::REQ_CHAR);
        it.ch    = ch;
        it.start = start;
        return it;
    endfunction

    // table writes and binary search, results left in step_res_q
    function automatic void decompose(input req_item_t it);
        int lo;
        int hi;
        int mid;
        int n;
        bit hit;
        step_res_q.delete();
        case (it.req)
            cdl_pkg::REQ_HDR:
            begin
                key_mem[it.idx] = it.key;
                len_mem[it.idx] = (it.len > 4'd8) ? 4'd8 : it.len;
            end
            cdl_pkg::REQ_EXP:
            begin
                exp_mem[{it.idx, it.pos}] = it.xch;
            end
            cdl_pkg::REQ_CHAR:
            begin
                if (it.start)
                begin
                    cnt_in  = '0;
                    cnt_out = '0;
                end
                lo  = 0;
                hi  = (cfg_count > DEPTH) ? DEPTH : int'(cfg_count);
                mid = 0;
                hit = 1'b0;
                while (lo < hi && !hit)
                begin
                    mid = (lo + hi) / 2;
                    if (it.ch < key_mem[mid])
                        hi = mid;
                    else if (key_mem[mid] < it.ch)
                        lo = mid + 1;
                    else
                        hit = 1'b1;
                end
                cnt_in = sat_inc(cnt_in);
                if (!hit)
                begin
                    cnt_out = sat_inc(cnt_out);
                    add_step('{it.ch, 1'b1, 1'b0, 32'd0, 32'd0, 1'b1});
                end
                else
                begin
                    n = int'(len_mem[mid]);
                    if (n == 0)
                        add_step('{16'h0000, 1'b0, 1'b1, cnt_in, cnt_out, 1'b1});
                    for (int j = 0; j < n; j++)
                    begin
                        cnt_out = sat_inc(cnt_out);
                        if (j == n - 1)
                            add_step('{exp_mem[{10'(mid), 3'(j)}], 1'b1, 1'b1,
                                       cnt_in, cnt_out, 1'b1});
                        else
                            add_step('{exp_mem[{10'(mid), 3'(j)}], 1'b1, 1'b0,
                                       32'd0, 32'd0, 1'b0});
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic push_item(input req_item_t it, input logic typed, input result_t want);
        if ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        req_type       <= it.req;
        entry_index    <= it.idx;
        entry_key      <= it.key;
        entry_length   <= it.len;
        expansion_pos  <= it.pos;
        expansion_char <= it.xch;
        in_char        <= it.ch;
        string_start   <= it.start;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decompose(it);
        if (typed)
            out_due_q = {out_due_q, want};
        else
            while (step_res_q.size() != 0)
                out_due_q = {out_due_q, step_res_q.pop_front()};
    endtask

    task automatic load_count(input logic [10:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        while (out_due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
        entry_count_we <= 1'b1;
        entry_count    <= val;
        @(negedge clk);
        entry_count_we <= 1'b0;
        cfg_count = val;
    endtask

    task automatic run_phase(input logic [10:0] cnt, input int send_pct, input int stall_pct,
                             input bit hold, input int n_chars);
        int          chars;
        int          sel;
        int          eff;
        int          nx;
        logic [9:0]  idx;
        logic [15:0] key;
        logic [3:0]  len;
        load_count(cnt);
        send_idle_pct = send_pct;
        rcv_stall_pct = stall_pct;
        if (hold)
            hold_asks++;
        chars = 0;
        eff   = (cnt > FILL) ? FILL : int'(cnt);
        while (chars < n_chars)
        begin
            sel = $urandom_range(99);
            if (sel < 70)
            begin
                if (eff > 0 && $urandom_range(1) == 1)
                    key = key_mem[$urandom_range(eff - 1)];
                else if ($urandom_range(7) == 0)
                    key = 16'hFFFF;
                else
                    key = 16'($urandom);
                push_item(char_item(key, $urandom_range(9) == 0), 1'b0, blank_res);
                chars++;
            end
            else if (sel < 84)
            begin
                // rewrite an entry, then fill its expansion
                idx = 10'($urandom_range(FILL - 1));
                len = 4'($urandom);
                key = ($urandom_range(2) == 0) ? 16'($urandom) : key_mem[idx];
                push_item(hdr_item(idx, key, len), 1'b0, blank_res);
                nx = (len > MAX_EXP) ? MAX_EXP : int'(len);
                for (int p = 0; p < nx; p++)
                    push_item(exp_item(idx, 3'(p), 16'($urandom)), 1'b0, blank_res);
            end
            else if (sel < 93)
                push_item(exp_item(10'($urandom), 3'($urandom), 16'($urandom)), 1'b0, blank_res);
            else
                push_item(any_item(REQ_NONE), 1'b0, blank_res);
        end
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_asks)
            begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: mismatch on %s: got %h, want %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : out_check
        result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (out_due_q.size() == 0)
                report_mismatch("unexpected item, out_char", out_char, 32'd0);
            else
            begin
                e = out_due_q.pop_front();
                if (out_char !== e.out_char)
                    report_mismatch("out_char", out_char, e.out_char);
                if (char_valid !== e.char_valid)
                    report_mismatch("char_valid", char_valid, e.char_valid);
                if (map_valid !== e.map_valid)
                    report_mismatch("map_valid", map_valid, e.map_valid);
                if (map_in_pos !== e.in_pos)
                    report_mismatch("map_in_pos", map_in_pos, e.in_pos);
                if (map_out_pos !== e.out_pos)
                    report_mismatch("map_out_pos", map_out_pos, e.out_pos);
                if (last !== e.last)
                    report_mismatch("last", last, e.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        logic [15:0] key;
        logic [3:0]  len;
        int          nx;
        rst_n          = 1'b0;
        entry_count_we = 1'b0;
        entry_count    = '0;
        in_valid       = 1'b0;
        req_type       = '0;
        entry_index    = '0;
        entry_key      = '0;
        entry_length   = '0;
        expansion_pos  = '0;
        expansion_char = '0;
        in_char        = '0;
        string_start   = 1'b0;
        cnt_in         = '0;
        cnt_out        = '0;
        cfg_count      = '0;
        key            = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table after reset: everything passes through
        add_row('{ROW_ITEM, char_item(16'h0000, 1'b1), 11'd0, 1'b1,
                  '{16'h0000, 1'b1, 1'b0, 32'd0, 32'd0, 1'b1}});
        add_row('{ROW_ITEM, char_item(16'hFFFF, 1'b0), 11'd0, 1'b1,
                  '{16'hFFFF, 1'b1, 1'b0, 32'd0, 32'd0, 1'b1}});
        add_row('{ROW_ITEM, any_item(REQ_NONE), 11'd0, 1'b0, blank_res});
        // empty expansion, long length clamped, top key
        add_row('{ROW_ITEM, hdr_item(10'd0, 16'h0041, 4'd0), 11'd0, 1'b0, blank_res});
        add_row('{ROW_ITEM, hdr_item(10'd1, 16'h00C5, 4'd15), 11'd0, 1'b0, blank_res});
        for (int p = 0; p < MAX_EXP; p++)
            add_row('{ROW_ITEM, exp_item(10'd1, 3'(p), 16'($urandom)), 11'd0, 1'b0,
                      blank_res});
        add_row('{ROW_ITEM, hdr_item(10'd2, 16'hFFFF, 4'd1), 11'd0, 1'b0, blank_res});
        add_row('{ROW_ITEM, exp_item(10'd2, 3'd0, 16'h0000), 11'd0, 1'b0, blank_res});
        add_row('{ROW_CFG, any_item(REQ_NONE), 11'd3, 1'b0, blank_res});
        add_row('{ROW_ITEM, char_item(16'h0041, 1'b1), 11'd0, 1'b1,
                  '{16'h0000, 1'b0, 1'b1, 32'd1, 32'd0, 1'b1}});
        add_row('{ROW_ITEM, char_item(16'h00C5, 1'b0), 11'd0, 1'b0, blank_res});
        add_row('{ROW_ITEM, char_item(16'hFFFF, 1'b0), 11'd0, 1'b0, blank_res});
        add_row('{ROW_ITEM, char_item(16'h0042, 1'b0), 11'd0, 1'b0, blank_res});
        add_row('{ROW_ITEM, char_item(16'h0000, 1'b0), 11'd0, 1'b0, blank_res});
        add_row('{ROW_ITEM, char_item(16'h00C5, 1'b1), 11'd0, 1'b0, blank_res});

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                load_count(dir_rows[i].count_val);
            else
                push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end

        // fill the low entries in ascending key order, with some equal keys
        for (int k = 0; k < FILL; k++)
        begin
            if (k == 0)
                key = 16'h0000;
            else if ($urandom_range(9) != 0)
                key = 16'(k * 64 + $urandom_range(63));
            len = ($urandom_range(15) == 0) ? 4'($urandom_range(15, 8)) : 4'($urandom_range(2));
            push_item(hdr_item(10'(k), key, len), 1'b0, blank_res);
            nx = (len > MAX_EXP) ? MAX_EXP : int'(len);
            for (int p = 0; p < nx; p++)
                push_item(exp_item(10'(k), 3'(p), 16'($urandom)), 1'b0, blank_res);
        end

        // first probes of a full-size search hold the top key, so wide searches
        // fall through to the low entries
        for (int s = FILL; s < DEPTH; s = s * 2)
            push_item(hdr_item(10'(s), 16'hFFFF, (s == DEPTH / 2) ? 4'd2 : 4'd0), 1'b0,
                      blank_res);
        for (int p = 0; p < 2; p++)
            push_item(exp_item(10'(DEPTH / 2), 3'(p), 16'($urandom)), 1'b0, blank_res);

        run_phase(11'd1024, 0, 0, 1'b1, 12);
        run_phase(11'd2047, 80, 0, 1'b0, 12);
        run_phase(11'd1, 0, 80, 1'b0, 10);
        run_phase(11'($urandom_range(FILL, 2)), 14, 14, 1'b0, 14);
        run_phase(11'd0, 0, 0, 1'b0, 10);

        @(negedge clk);
        in_valid <= 1'b0;
        while (out_due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
